@@ hw/rtl/c8_pkg.sv @@
// ----------------------------------------------------------------------------
// c8_pkg: shared types and constants of the CHIP-8 instruction core
// Beat structs, action codes, back-end state encoding and the font table.
// ----------------------------------------------------------------------------
package c8_pkg;

  localparam int MemBytes   = 4096;
  localparam int MemAw      = $clog2(MemBytes);
  localparam int StackDepth = 16;
  localparam int SpW        = 5;
  localparam int ScrRows    = 32;
  localparam logic [11:0] ProgStart = 12'h200;
  localparam int FontBytes  = 80;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_EXEC  = 2'd1,
    ACT_ROW   = 2'd2,
    ACT_NONE  = 2'd3
  } act_t;

  typedef struct packed {
    logic [1:0]  action;
    logic [11:0] address;
    logic [7:0]  data_byte;
    logic [15:0] key_mask;
    logic [7:0]  random_byte;
  } in_beat_t;

  typedef struct packed {
    logic [11:0] program_counter;
    logic [15:0] executed_opcode;
    logic        draw_flag;
    logic        waiting_key;
    logic        sound_on;
    logic        stack_fault;
    logic [63:0] display_row;
  } out_beat_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_FETCH_HI,
    ST_FETCH_LO,
    ST_FETCH_WT,
    ST_EXEC,
    ST_FB_CLR,
    ST_STACK_RD,
    ST_DRAW_RD,
    ST_DRAW_WR,
    ST_BCD,
    ST_STORE,
    ST_LOAD_RD,
    ST_LOAD_WR,
    ST_DONE
  } be_state_t;

  function automatic logic [7:0] font_byte(input logic [6:0] idx);
    logic [7:0] f;
    case (idx)
      7'd0: f = 8'hF0;  7'd1: f = 8'h90;  7'd2: f = 8'h90;  7'd3: f = 8'h90;
      7'd4: f = 8'hF0;  7'd5: f = 8'h20;  7'd6: f = 8'h60;  7'd7: f = 8'h20;
      7'd8: f = 8'h20;  7'd9: f = 8'h70;  7'd10: f = 8'hF0; 7'd11: f = 8'h10;
      7'd12: f = 8'hF0; 7'd13: f = 8'h80; 7'd14: f = 8'hF0; 7'd15: f = 8'hF0;
      7'd16: f = 8'h10; 7'd17: f = 8'hF0; 7'd18: f = 8'h10; 7'd19: f = 8'hF0;
      7'd20: f = 8'h90; 7'd21: f = 8'h90; 7'd22: f = 8'hF0; 7'd23: f = 8'h10;
      7'd24: f = 8'h10; 7'd25: f = 8'hF0; 7'd26: f = 8'h80; 7'd27: f = 8'hF0;
      7'd28: f = 8'h10; 7'd29: f = 8'hF0; 7'd30: f = 8'hF0; 7'd31: f = 8'h80;
      7'd32: f = 8'hF0; 7'd33: f = 8'h90; 7'd34: f = 8'hF0; 7'd35: f = 8'hF0;
      7'd36: f = 8'h10; 7'd37: f = 8'h20; 7'd38: f = 8'h40; 7'd39: f = 8'h40;
      7'd40: f = 8'hF0; 7'd41: f = 8'h90; 7'd42: f = 8'hF0; 7'd43: f = 8'h90;
      7'd44: f = 8'hF0; 7'd45: f = 8'hF0; 7'd46: f = 8'h90; 7'd47: f = 8'hF0;
      7'd48: f = 8'h10; 7'd49: f = 8'hF0; 7'd50: f = 8'hF0; 7'd51: f = 8'h90;
      7'd52: f = 8'hF0; 7'd53: f = 8'h90; 7'd54: f = 8'h90; 7'd55: f = 8'hE0;
      7'd56: f = 8'h90; 7'd57: f = 8'hE0; 7'd58: f = 8'h90; 7'd59: f = 8'hE0;
      7'd60: f = 8'hF0; 7'd61: f = 8'h80; 7'd62: f = 8'h80; 7'd63: f = 8'h80;
      7'd64: f = 8'hF0; 7'd65: f = 8'hE0; 7'd66: f = 8'h90; 7'd67: f = 8'h90;
      7'd68: f = 8'h90; 7'd69: f = 8'hE0; 7'd70: f = 8'hF0; 7'd71: f = 8'h80;
      7'd72: f = 8'hF0; 7'd73: f = 8'h80; 7'd74: f = 8'hF0; 7'd75: f = 8'hF0;
      7'd76: f = 8'h80; 7'd77: f = 8'hF0; 7'd78: f = 8'h80; 7'd79: f = 8'h80;
      default: f = 8'h00;
    endcase
    return f;
  endfunction

endpackage

@@ hw/rtl/chip8_instruction_core.sv @@
// ----------------------------------------------------------------------------
// chip8_instruction_core: CHIP-8 interpreter core
//
//  channel | signals                    | direction
//  command | start, busy, in_beat       | in
//  result  | out_valid, out_beat        | out (one cycle strobe)
//
// A write, row read or unused beat passes from idle straight to the done state;
// an instruction adds fetch-high, fetch-low, fetch-wait and exec states (two
// fetch reads through the single memory port); the strobe is registered in done.
// A sprite draw adds a read and a write state per row, 00E0 a sweep of the
// frame-buffer rows, 00EE a stack read, Fx33 a write per BCD digit, Fx55 a
// store per register and Fx65 a read and a write per register. After reset a
// sweep loads the font and clears memory and the frame buffer; busy rises once
// two commands are queued. The receiver cannot stall results.
module chip8_instruction_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  c8_pkg::in_beat_t  in_beat,
  output logic              out_valid,
  output c8_pkg::out_beat_t out_beat
);
  import c8_pkg::*;

  logic     q_valid, q_pop;
  in_beat_t q_beat;

  c8_front u_front (
    .clk, .rst_n, .start, .busy, .in_beat, .q_valid, .q_beat, .q_pop
  );

  c8_back u_back (
    .clk, .rst_n, .q_valid, .q_beat, .q_pop, .out_valid, .out_beat
  );

endmodule

@@ hw/rtl/c8_front.sv @@
// ----------------------------------------------------------------------------
// c8_front: command intake and two-entry beat queue
// Takes command beats while the queue has room and hands them to the back end.
// ----------------------------------------------------------------------------
module c8_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  c8_pkg::in_beat_t  in_beat,
  output logic              q_valid,
  output c8_pkg::in_beat_t  q_beat,
  input  logic              q_pop
);
  import c8_pkg::*;

  in_beat_t   slot_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic       rd_r, rd_nxt;
  logic       wr_r, wr_nxt;
  logic       push;

  assign busy    = (cnt_r == 2'd2);
  assign push    = start && !busy;
  assign q_valid = (cnt_r != 2'd0);
  assign q_beat  = slot_r[rd_r];

  // occupancy and pointers
  always_comb begin
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
    rd_nxt  = q_pop ? ~rd_r : rd_r;
    wr_nxt  = push ? ~wr_r : wr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r  <= 1'b0;
      wr_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r  <= rd_nxt;
      wr_r  <= wr_nxt;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    if (push) slot_r[wr_r] <= in_beat;
  end

endmodule

@@ hw/rtl/c8_back.sv @@
// ----------------------------------------------------------------------------
// c8_back: instruction sequencer
// Owns memory, registers, stack and frame buffer; runs one beat at a time.
// ----------------------------------------------------------------------------
module c8_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  input  c8_pkg::in_beat_t  q_beat,
  output logic              q_pop,
  output logic              out_valid,
  output c8_pkg::out_beat_t out_beat
);
  import c8_pkg::*;

  // storage
  logic [7:0]  mem [MemBytes];
  logic [63:0] fb  [ScrRows];
  logic [11:0] stk [StackDepth];
  logic [7:0]  v_r [16];

  be_state_t   st_r, st_nxt;
  in_beat_t    cur_r;
  logic [11:0] pc_r, idx_clr_r;
  logic [15:0] i_r, op_r;
  logic [SpW-1:0] sp_r;
  logic [7:0]  dt_r, st8_r;
  logic [3:0]  cnt_r;
  logic [7:0]  mdat_r;
  logic [63:0] row_r;
  logic [11:0] stk_dat_r;
  logic        hit_r, drawn_r, wait_r, fault_r;
  logic        clr_done_r;

  // memory port
  logic        m_we;
  logic [MemAw-1:0] m_addr;
  logic [7:0]  m_wd;

  logic [3:0]  x, y, n;
  logic [7:0]  kk, vx, vy;
  logic [11:0] nnn;
  logic [4:0]  drow;
  logic [63:0] smask;
  logic [7:0]  bcd_d;
  logic [11:0] pc2, pc4;

  assign x   = op_r[11:8];
  assign y   = op_r[7:4];
  assign n   = op_r[3:0];
  assign kk  = op_r[7:0];
  assign nnn = op_r[11:0];
  assign vx  = v_r[x];
  assign vy  = v_r[y];
  assign pc2 = pc_r + 12'd2;
  assign pc4 = pc_r + 12'd4;
  assign drow = vy[4:0] + {1'b0, cnt_r};

  // sprite byte placed at column vx, wrapping across the row
  always_comb begin
    logic [63:0] base;
    base  = {mdat_r, 56'd0};
    smask = (base >> vx[5:0]) | (base << (7'd64 - {1'b0, vx[5:0]}));
    if (vx[5:0] == 6'd0) smask = base;
  end

  // BCD digit for the current step; tens by reciprocal multiply (t < 100)
  always_comb begin
    logic [7:0]  t;
    logic [15:0] prod;
    logic [7:0]  tens;
    t    = (vx >= 8'd200) ? vx - 8'd200 : (vx >= 8'd100) ? vx - 8'd100 : vx;
    prod = {8'd0, t} * 16'd205;
    tens = {3'd0, prod[15:11]};
    case (cnt_r)
      4'd0:    bcd_d = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
      4'd1:    bcd_d = tens;
      default: bcd_d = t - {tens[4:0], 3'd0} - {tens[6:0], 1'b0};
    endcase
  end

  // next state
  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      ST_CLEAR:    if (clr_done_r) st_nxt = ST_IDLE;
      ST_IDLE: begin
        if (q_valid) begin
          if (q_beat.action == ACT_EXEC) st_nxt = ST_FETCH_HI;
          else st_nxt = ST_DONE;
        end
      end
      ST_FETCH_HI: st_nxt = ST_FETCH_LO;
      ST_FETCH_LO: st_nxt = ST_FETCH_WT;
      ST_FETCH_WT: st_nxt = ST_EXEC;
      ST_EXEC: begin
        unique case (op_r[15:12])
          4'h0: begin
            if (op_r == 16'h00E0) st_nxt = ST_FB_CLR;
            else st_nxt = (op_r == 16'h00EE && sp_r != '0 && sp_r <= SpW'(StackDepth))
                          ? ST_STACK_RD : ST_DONE;
          end
          4'hD: st_nxt = (n == 4'd0) ? ST_DONE : ST_DRAW_RD;
          4'hF: begin
            case (kk)
              8'h33:   st_nxt = ST_BCD;
              8'h55:   st_nxt = ST_STORE;
              8'h65:   st_nxt = ST_LOAD_RD;
              default: st_nxt = ST_DONE;
            endcase
          end
          default: st_nxt = ST_DONE;
        endcase
      end
      ST_FB_CLR:   st_nxt = (idx_clr_r[4:0] == 5'd31) ? ST_DONE : ST_FB_CLR;
      ST_STACK_RD: st_nxt = ST_DONE;
      ST_DRAW_RD:  st_nxt = ST_DRAW_WR;
      ST_DRAW_WR:  st_nxt = (cnt_r == n - 4'd1) ? ST_DONE : ST_DRAW_RD;
      ST_BCD:      st_nxt = (cnt_r == 4'd2) ? ST_DONE : ST_BCD;
      ST_STORE:    st_nxt = (cnt_r == x) ? ST_DONE : ST_STORE;
      ST_LOAD_RD:  st_nxt = ST_LOAD_WR;
      ST_LOAD_WR:  st_nxt = (cnt_r == x) ? ST_DONE : ST_LOAD_RD;
      ST_DONE:     st_nxt = ST_IDLE;
      default:     st_nxt = ST_IDLE;
    endcase
  end

  // memory port selection
  always_comb begin
    m_we   = 1'b0;
    m_addr = cur_r.address;
    m_wd   = cur_r.data_byte;
    unique case (st_r)
      ST_CLEAR: begin
        m_we   = 1'b1;
        m_addr = idx_clr_r;
        m_wd   = (idx_clr_r < 12'(FontBytes)) ? font_byte(idx_clr_r[6:0]) : 8'd0;
      end
      ST_DONE:     m_we = (cur_r.action == ACT_WRITE);
      ST_FETCH_HI: m_addr = pc_r;
      ST_FETCH_LO: m_addr = pc_r + 12'd1;
      ST_DRAW_RD, ST_LOAD_RD: m_addr = i_r[11:0] + {8'd0, cnt_r};
      ST_BCD: begin
        m_we = 1'b1; m_addr = i_r[11:0] + {8'd0, cnt_r}; m_wd = bcd_d;
      end
      ST_STORE: begin
        m_we = 1'b1; m_addr = i_r[11:0] + {8'd0, cnt_r}; m_wd = v_r[cnt_r];
      end
      default: ;
    endcase
  end

  // main memory
  always_ff @(posedge clk) begin
    if (m_we) mem[m_addr] <= m_wd;
    mdat_r <= mem[m_addr];
  end

  // frame buffer row port; clears sweep one row a cycle
  always_ff @(posedge clk) begin
    if (st_r == ST_CLEAR || st_r == ST_FB_CLR)
      fb[idx_clr_r[4:0]] <= 64'd0;
    else if (st_r == ST_DRAW_WR)
      fb[drow] <= row_r ^ smask;
    row_r <= fb[(st_r == ST_IDLE) ? q_beat.address[4:0] : drow];
  end

  // return stack
  always_ff @(posedge clk) begin
    if (st_r == ST_EXEC && op_r[15:12] == 4'h2 && sp_r < SpW'(StackDepth))
      stk[sp_r[3:0]] <= pc_r;
    stk_dat_r <= stk[sp_r[3:0] - 4'd1];
  end

  // control and register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_CLEAR;
      idx_clr_r  <= '0;
      clr_done_r <= 1'b0;
      pc_r       <= ProgStart;
      i_r        <= '0;
      sp_r       <= '0;
      dt_r       <= '0;
      st8_r      <= '0;
      out_valid  <= 1'b0;
      for (int k = 0; k < 16; k++) v_r[k] <= '0;
    end else begin
      st_r      <= st_nxt;
      out_valid <= 1'b0;
      unique case (st_r)
        ST_CLEAR: begin
          idx_clr_r  <= idx_clr_r + 12'd1;
          clr_done_r <= (idx_clr_r == 12'(MemBytes - 2));
        end
        ST_IDLE: begin
          cur_r   <= q_beat;
          op_r    <= '0;
          cnt_r   <= '0;
          hit_r   <= 1'b0;
          drawn_r <= 1'b0;
          wait_r  <= 1'b0;
          fault_r <= 1'b0;
          idx_clr_r <= '0;
        end
        ST_FETCH_HI: ;
        ST_FETCH_LO: op_r[15:8] <= mdat_r;
        // low opcode byte lands in the cycle after the high byte
        ST_FETCH_WT: op_r[7:0] <= mdat_r;
        ST_EXEC: begin
          pc_r <= pc2;
          unique case (op_r[15:12])
            4'h0: begin
              if (op_r == 16'h00E0) begin
                drawn_r <= 1'b1;
              end else if (op_r == 16'h00EE) begin
                if (sp_r == '0 || sp_r > SpW'(StackDepth)) fault_r <= 1'b1;
                else sp_r <= sp_r - 1'b1;
              end
            end
            4'h1: pc_r <= nnn;
            4'h2: begin
              if (sp_r >= SpW'(StackDepth)) fault_r <= 1'b1;
              else begin sp_r <= sp_r + 1'b1; pc_r <= nnn; end
            end
            4'h3: if (vx == kk) pc_r <= pc4;
            4'h4: if (vx != kk) pc_r <= pc4;
            4'h5: if (vx == vy) pc_r <= pc4;
            4'h6: v_r[x] <= kk;
            4'h7: v_r[x] <= vx + kk;
            4'h8: begin
              case (n)
                4'h0: v_r[x] <= vy;
                4'h1: v_r[x] <= vx | vy;
                4'h2: v_r[x] <= vx & vy;
                4'h3: v_r[x] <= vx ^ vy;
                4'h4: begin
                  v_r[x] <= vx + vy;
                  v_r[15] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'hFF};
                end
                4'h5: begin v_r[x] <= vx - vy; v_r[15] <= {7'd0, vx >= vy}; end
                4'h6: begin v_r[x] <= vx >> 1; v_r[15] <= {7'd0, vx[0]}; end
                4'h7: begin v_r[x] <= vy - vx; v_r[15] <= {7'd0, vy >= vx}; end
                4'hE: begin v_r[x] <= vx << 1; v_r[15] <= {7'd0, vx[7]}; end
                default: ;
              endcase
            end
            4'h9: if (vx != vy) pc_r <= pc4;
            4'hA: i_r <= {4'd0, nnn};
            4'hB: pc_r <= nnn + {4'd0, v_r[0]};
            4'hC: v_r[x] <= cur_r.random_byte & kk;
            4'hD: begin
              drawn_r <= 1'b1;
              // zero-row sprite draws nothing, so no collision
              if (n == 4'd0) v_r[15] <= 8'd0;
            end
            4'hE: begin
              if (kk == 8'h9E && vx < 8'd16 && cur_r.key_mask[vx[3:0]]) pc_r <= pc4;
              if (kk == 8'hA1 && !(vx < 8'd16 && cur_r.key_mask[vx[3:0]])) pc_r <= pc4;
            end
            default: begin
              case (kk)
                8'h07: v_r[x] <= dt_r;
                8'h0A: begin
                  if (cur_r.key_mask == 16'd0) begin
                    wait_r <= 1'b1;
                    pc_r   <= pc_r;
                  end else begin
                    for (int k = 0; k < 16; k++)
                      if (cur_r.key_mask[k]) v_r[x] <= 8'(k);
                  end
                end
                8'h15: dt_r  <= vx;
                8'h18: st8_r <= vx;
                8'h1E: begin
                  i_r <= i_r + {8'd0, vx};
                  v_r[15] <= {7'd0, (i_r + {8'd0, vx}) > 16'h0FFF};
                end
                8'h29: i_r <= {8'd0, vx} * 16'd5;
                default: ;
              endcase
            end
          endcase
        end
        ST_FB_CLR: idx_clr_r <= idx_clr_r + 12'd1;
        ST_STACK_RD: pc_r <= stk_dat_r + 12'd2;
        ST_DRAW_RD: ;
        ST_DRAW_WR: begin
          if ((row_r & smask) != 64'd0) hit_r <= 1'b1;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == n - 4'd1)
            v_r[15] <= {7'd0, hit_r || ((row_r & smask) != 64'd0)};
        end
        ST_BCD:   cnt_r <= cnt_r + 4'd1;
        ST_STORE: begin
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == x) i_r <= i_r + {12'd0, x} + 16'd1;
        end
        ST_LOAD_RD: ;
        ST_LOAD_WR: begin
          v_r[cnt_r] <= mdat_r;
          cnt_r <= cnt_r + 4'd1;
          if (cnt_r == x) i_r <= i_r + {12'd0, x} + 16'd1;
        end
        ST_DONE: begin
          out_valid <= 1'b1;
          if (cur_r.action == ACT_EXEC) begin
            if (dt_r != 8'd0) dt_r <= dt_r - 8'd1;
            if (st8_r != 8'd0) st8_r <= st8_r - 8'd1;
          end
        end
        default: ;
      endcase
      // 00E0 clear sweep reuses the reset-clear counter, zeroed again in fetch-low
      if (st_r == ST_FETCH_LO) idx_clr_r <= '0;
    end
  end

  assign q_pop = (st_r == ST_IDLE) && q_valid;

  // result register; sound state is taken after this beat's countdown
  always_ff @(posedge clk) begin
    if (st_r == ST_DONE) begin
      out_beat.program_counter <= pc_r;
      out_beat.executed_opcode <= op_r;
      out_beat.draw_flag       <= drawn_r;
      out_beat.waiting_key     <= wait_r;
      out_beat.sound_on        <= (cur_r.action == ACT_EXEC) ? (st8_r > 8'd1)
                                                             : (st8_r != 8'd0);
      out_beat.stack_fault     <= fault_r;
      out_beat.display_row     <= (cur_r.action == ACT_ROW) ? row_r : 64'd0;
    end
  end

endmodule
